@@ src/mfs_pkg.sv @@
// Shared types, codes and constants of the monochrome frame scanout block.
package mfs_pkg;

   // Default panel geometry
   localparam int DEF_WIDTH  = 96;
   localparam int DEF_HEIGHT = 68;
   localparam int DEF_PAGES  = 9;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PANEL_KIND   = 3'd0,
      CSR_PIXEL_FORMAT = 3'd1,
      CSR_MIRROR_X     = 3'd2,
      CSR_INVERT       = 3'd3,
      CSR_FG_COLOR     = 3'd4,
      CSR_BG_COLOR     = 3'd5
   } csr_index_type;

   // Input item kinds
   typedef enum logic [1:0] {
      KIND_SET_PIXEL = 2'd0,
      KIND_FILL      = 2'd1,
      KIND_START     = 2'd2,
      KIND_ADVANCE   = 2'd3
   } kind_type;

   localparam logic PANEL_PAGE  = 1'b0;
   localparam logic PANEL_COLOR = 1'b1;

   localparam logic [1:0] FMT_8  = 2'd0;
   localparam logic [1:0] FMT_12 = 2'd1;

   localparam logic [1:0] HEADER_DONE = 2'd3;

   // Panel command bytes
   localparam logic [7:0] CMD_PAGE_ADDR = 8'hB0;
   localparam logic [7:0] CMD_COL_HI    = 8'h10;
   localparam logic [7:0] CMD_COL_LO    = 8'h00;
   localparam logic [7:0] CMD_RAM_WRITE = 8'h2C;

   // Where the output byte comes from
   typedef enum logic [2:0] {
      SEL_CONST,   // command byte carried from the sequencer
      SEL_PAGE,    // store byte, optionally inverted
      SEL_LO,      // colour bits 7:0
      SEL_MID,     // colour bits 11:4, low nibble is held
      SEL_HI,      // colour bits 15:8
      SEL_PACK     // held nibble OR colour bits 15:12, then colour bits 11:8
   } sel_type;

   function automatic logic [7:0] page_header(input logic [1:0] step);
      logic [7:0] cmd;
      unique case (step)
         2'd0:    cmd = CMD_PAGE_ADDR;
         2'd1:    cmd = CMD_COL_HI;
         default: cmd = CMD_COL_LO;
      endcase
      return cmd;
   endfunction

endpackage

@@ src/mfs_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mfs_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ src/mono_frame_scanout.sv @@
// Monochrome frame store with LCD byte scanout. The store holds PAGES pages of WIDTH byte
// columns (one bit per pixel) in eight one-bit-wide RAM lanes, so a set pixel item is a
// single lane write. Set pixel, start and advance items are taken one per cycle while the
// result output is not stalled; a result passes the input register, the read stage and the
// output register, and while a result waits the pipeline holds, so a new item enters only
// an empty input register. A fill item holds off input while the store's single write
// port sweeps every entry, and the same clearing pass with a zero byte runs after reset
// before the first item is taken. Configuration writes are taken at any time.
module mono_frame_scanout
   import mfs_pkg::*;
#(
   parameter int WIDTH  = mfs_pkg::DEF_WIDTH,
   parameter int HEIGHT = mfs_pkg::DEF_HEIGHT,
   parameter int PAGES  = mfs_pkg::DEF_PAGES
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // x, y, pixel_on, fill_byte, zero pad
   input  logic [1:0]                     req_tuser,  // kind
   // Result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,  // lcd_byte
   output logic [0:0]                     rsp_tuser,  // is_data
   output logic                           rsp_tlast,
   // Register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfs_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int STORE_DEPTH = WIDTH * PAGES;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int PW          = 14;  // wide enough for any page * WIDTH + column

   localparam logic [7:0]    W_LAST    = 8'(WIDTH - 1);
   localparam logic [7:0]    H_LAST    = 8'(HEIGHT - 1);
   localparam logic [7:0]    P_LAST    = 8'(PAGES - 1);
   localparam logic [7:0]    WIDTH_B   = 8'(WIDTH);
   localparam logic [7:0]    HEIGHT_B  = 8'(HEIGHT);
   localparam logic [7:0]    PAGES_B   = 8'(PAGES);
   localparam logic [5:0]    PAGES_C   = 6'(PAGES);
   localparam logic [AW-1:0] STORE_END = AW'(STORE_DEPTH - 1);

   // Configuration registers
   logic        panel_kind_ff;
   logic [1:0]  pixel_format_ff;
   logic        mirror_x_ff;
   logic        invert_ff;
   logic [15:0] fg_color_ff;
   logic [15:0] bg_color_ff;

   // Input register
   logic        v1_ff;
   kind_type    kind_ff;
   logic [7:0]  x_ff, y_ff, fill_ff;
   logic        on_ff;

   // Scan state
   logic        refresh_ff, refresh_in;
   logic [1:0]  header_ff, header_in;
   logic [7:0]  row_ff, row_in;
   logic [7:0]  col_ff, col_in;
   logic        phase_ff, phase_in;
   logic        odd_ff, odd_in;

   // Fill / clear sweep
   logic          sweep_ff, sweep_in;
   logic [AW-1:0] sweep_addr_ff, sweep_addr_in;
   logic [7:0]    fill_val_ff, fill_val_in;

   // Read stage
   logic        v2_ff;
   sel_type     sel_ff;
   logic [7:0]  byte_ff;
   logic        data_ff, last_ff, zero_ff, hold_ff;
   logic [2:0]  lane_ff;
   logic [3:0]  held_ff;

   // Output register
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_data_ff, out_last_ff;

   logic        adv, s1_go;

   // Sequencer outputs
   logic        res_in, data_in, last_in, zero_in, hold_in, rd_req, step_col;
   sel_type     sel_in;
   logic [7:0]  byte_in;
   logic [2:0]  lane_in;

   // Store access
   logic [7:0]    scan_col;
   logic [4:0]    page_idx;
   logic [PW-1:0] rd_full;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [7:0]    ram_q;
   logic [7:0]    wr_we;
   logic [7:0]    wr_bits;
   logic [AW-1:0] wr_addr;
   logic [7:0]    set_d;
   logic [7:0]    set_col;
   logic [PW-1:0] set_full;
   logic          set_ok;

   // Output formatting
   logic        pix_bit;
   logic [15:0] color;
   logic [7:0]  out_byte_in;

   assign adv        = !out_valid_ff || rsp_tready;
   assign s1_go      = v1_ff && adv && !sweep_ff;
   assign req_tready = (!v1_ff || s1_go) && !sweep_ff;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tuser[0] = out_data_ff;
   assign rsp_tlast    = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_kind_ff   <= PANEL_COLOR;
         pixel_format_ff <= 2'd2;
         mirror_x_ff     <= 1'b0;
         invert_ff       <= 1'b0;
         fg_color_ff     <= 16'hF800;
         bg_color_ff     <= 16'h0000;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PANEL_KIND:   panel_kind_ff   <= csr_data[0];
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_data[1:0];
            CSR_MIRROR_X:     mirror_x_ff     <= csr_data[0];
            CSR_INVERT:       invert_ff       <= csr_data[0];
            CSR_FG_COLOR:     fg_color_ff     <= csr_data;
            CSR_BG_COLOR:     bg_color_ff     <= csr_data;
            default:          ;  // drop writes beyond the register list
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (req_tready) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         kind_ff <= kind_type'(req_tuser);
         x_ff    <= req_tdata[7:0];
         y_ff    <= req_tdata[15:8];
         on_ff   <= req_tdata[16];
         fill_ff <= req_tdata[24:17];
      end
   end

   // Store address of the pixel or byte being scanned
   assign scan_col = mirror_x_ff ? (W_LAST - col_ff) : col_ff;
   assign page_idx = (panel_kind_ff == PANEL_PAGE) ? row_ff[4:0] : row_ff[7:3];
   assign rd_full  = PW'(page_idx) * PW'(WIDTH) + PW'(scan_col);
   assign rd_addr  = rd_full[AW-1:0];
   assign rd_en    = s1_go && rd_req;

   // Scan sequencer
   always_comb begin
      refresh_in = refresh_ff;
      header_in  = header_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      phase_in   = phase_ff;
      odd_in     = odd_ff;
      res_in     = 1'b0;
      sel_in     = SEL_CONST;
      byte_in    = 8'h00;
      data_in    = 1'b1;
      last_in    = 1'b0;
      lane_in    = row_ff[2:0];
      zero_in    = {1'b0, page_idx} >= PAGES_C;
      hold_in    = 1'b0;
      rd_req     = 1'b0;
      step_col   = 1'b0;
      if (s1_go) begin
         unique case (kind_ff)
            KIND_START: begin
               refresh_in = 1'b1;
               header_in  = 2'd0;
               row_in     = 8'd0;
               col_in     = 8'd0;
               phase_in   = 1'b0;
               odd_in     = 1'b0;
            end
            KIND_ADVANCE: begin
               if (refresh_ff) begin
                  if (panel_kind_ff == PANEL_PAGE) begin
                     if (header_ff != HEADER_DONE) begin
                        res_in    = 1'b1;
                        byte_in   = page_header(header_ff);
                        data_in   = 1'b0;
                        header_in = header_ff + 2'd1;
                     end else if (row_ff >= PAGES_B) begin
                        refresh_in = 1'b0;
                     end else begin
                        res_in   = 1'b1;
                        sel_in   = SEL_PAGE;
                        rd_req   = 1'b1;
                        step_col = 1'b1;
                     end
                  end else begin
                     if (header_ff != HEADER_DONE) begin
                        res_in    = 1'b1;
                        byte_in   = CMD_RAM_WRITE;
                        data_in   = 1'b0;
                        header_in = HEADER_DONE;
                     end else if (row_ff >= HEIGHT_B) begin
                        refresh_in = 1'b0;
                     end else begin
                        res_in = 1'b1;
                        rd_req = 1'b1;
                        unique case (pixel_format_ff)
                           FMT_8: begin
                              sel_in   = SEL_LO;
                              phase_in = 1'b0;
                              step_col = 1'b1;
                           end
                           FMT_12: begin
                              priority if (!odd_ff) begin
                                 sel_in   = SEL_MID;
                                 hold_in  = 1'b1;
                                 odd_in   = 1'b1;
                                 phase_in = 1'b0;
                                 step_col = 1'b1;
                              end else if (!phase_ff) begin
                                 sel_in   = SEL_PACK;
                                 phase_in = 1'b1;
                              end else begin
                                 sel_in   = SEL_LO;
                                 odd_in   = 1'b0;
                                 phase_in = 1'b0;
                                 step_col = 1'b1;
                              end
                           end
                           default: begin
                              if (!phase_ff) begin
                                 sel_in   = SEL_HI;
                                 phase_in = 1'b1;
                              end else begin
                                 sel_in   = SEL_LO;
                                 phase_in = 1'b0;
                                 step_col = 1'b1;
                              end
                           end
                        endcase
                     end
                  end
               end
            end
            default: ;  // set pixel and fill touch only the store
         endcase
         if (step_col) begin
            if (col_ff >= W_LAST) begin
               col_in = 8'd0;
               row_in = row_ff + 8'd1;
               if (row_ff >= ((panel_kind_ff == PANEL_PAGE) ? P_LAST : H_LAST)) begin
                  last_in    = 1'b1;
                  refresh_in = 1'b0;
               end
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_ff <= 1'b0;
         header_ff  <= 2'd0;
         row_ff     <= 8'd0;
         col_ff     <= 8'd0;
         phase_ff   <= 1'b0;
         odd_ff     <= 1'b0;
      end else begin
         refresh_ff <= refresh_in;
         header_ff  <= header_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         phase_ff   <= phase_in;
         odd_ff     <= odd_in;
      end
   end

   // Fill sweep; reset starts one with a zero byte
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      fill_val_in   = fill_val_ff;
      if (sweep_ff) begin
         if (sweep_addr_ff == STORE_END) begin
            sweep_in = 1'b0;
         end else begin
            sweep_addr_in = sweep_addr_ff + AW'(1);
         end
      end else if (s1_go && kind_ff == KIND_FILL) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
         fill_val_in   = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         fill_val_ff   <= 8'h00;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         fill_val_ff   <= fill_val_in;
      end
   end

   // Set pixel: rows and columns are stored flipped
   assign set_d    = H_LAST - y_ff;
   assign set_col  = W_LAST - x_ff;
   assign set_full = PW'(set_d[7:3]) * PW'(WIDTH) + PW'(set_col);
   assign set_ok   = (x_ff < WIDTH_B) && (y_ff < HEIGHT_B) && ({1'b0, set_d[7:3]} < PAGES_C);

   always_comb begin
      wr_we   = 8'h00;
      wr_bits = {8{on_ff}};
      wr_addr = set_full[AW-1:0];
      if (sweep_ff) begin
         wr_we   = 8'hFF;
         wr_bits = fill_val_ff;
         wr_addr = sweep_addr_ff;
      end else if (s1_go && kind_ff == KIND_SET_PIXEL && set_ok) begin
         wr_we = 8'h01 << set_d[2:0];
      end
   end

   for (genvar g = 0; g < 8; g++) begin : g_lane
      mfs_ram #(
         .DATA_W (1),
         .DEPTH  (STORE_DEPTH)
      ) u_lane (
         .clock   (clock),
         .wr_en   (wr_we[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_bits[g]),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (ram_q[g])
      );
   end

   // Read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= s1_go && res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_ff  <= sel_in;
         byte_ff <= byte_in;
         data_ff <= data_in;
         last_ff <= last_in;
         zero_ff <= zero_in;
         hold_ff <= hold_in;
         lane_ff <= lane_in;
      end
      if (adv && v2_ff && hold_ff) begin
         held_ff <= color[3:0];
      end
   end

   assign pix_bit = zero_ff ? 1'b0 : ram_q[lane_ff];
   assign color   = (pix_bit ^ invert_ff) ? fg_color_ff : bg_color_ff;

   always_comb begin
      unique case (sel_ff)
         SEL_CONST: out_byte_in = byte_ff;
         SEL_PAGE:  out_byte_in = ram_q ^ {8{invert_ff}};
         SEL_LO:    out_byte_in = color[7:0];
         SEL_MID:   out_byte_in = color[11:4];
         SEL_HI:    out_byte_in = color[15:8];
         SEL_PACK:  out_byte_in = {held_ff | color[15:12], color[11:8]};
         default:   out_byte_in = byte_ff;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_byte_ff <= out_byte_in;
         out_data_ff <= data_ff;
         out_last_ff <= last_ff;
      end
   end

   // Checks
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= W_LAST)
      else $error("column count beyond panel width");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> sweep_addr_ff <= STORE_END)
      else $error("sweep address beyond store");

   a_no_read_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_ff |-> !rd_en && !s1_go)
      else $error("store read or item processed during sweep");

   a_last_ends_refresh: assert property (@(posedge clock) disable iff (reset)
      (s1_go && res_in && last_in) |=> !refresh_ff)
      else $error("refresh still active after final byte");

endmodule
